@@ rtl/roulette_select_without_replacement_unit_macros.svh @@
// Assertion macros for the roulette select unit
`ifndef ROULETTE_SELECT_WITHOUT_REPLACEMENT_UNIT_MACROS_SVH
`define ROULETTE_SELECT_WITHOUT_REPLACEMENT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RSW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSW_ASSERT(label, clk, rst_n, prop, msg)
`define RSW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/rsw_pkg.sv @@
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and action codes for the roulette select unit.
// ----------------------------------------------------------------------------
package rsw_pkg;
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_SELECT = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;  // reserved, ignored

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_SUM  = 8'b00000010,
    ST_MOD  = 8'b00000100,
    ST_SCAN = 8'b00001000,
    ST_RD   = 8'b00010000,
    ST_OUT  = 8'b00100000,
    ST_EXH  = 8'b01000000,
    ST_CLR  = 8'b10000000
  } state_t;
endpackage

@@ rtl/roulette_select_without_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// roulette_select_without_replacement_unit
// Fitness-proportional selection without replacement over a chromosome table.
// Load: written while idle, busy stays low. Clear: busy while wiping every live mark.
// Select: busy through the sum pass, restoring modulo, scan, read and output
// steps; an exhausted select ends from the sum pass or the scan.
// Result strobe comes in the cycle busy drops; no stall.
// Sync active-low reset runs the same clear of the live marks.
// ----------------------------------------------------------------------------
`include "roulette_select_without_replacement_unit_macros.svh"
module roulette_select_without_replacement_unit
  import rsw_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_entry_index,
  input  logic [15:0] in_fitness,
  input  logic [31:0] in_chromosome_word,
  input  logic [31:0] in_random_value,
  output logic        out_valid,
  output logic [7:0]  out_chosen_index,
  output logic [31:0] out_chosen_chromosome,
  output logic        out_exhausted
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int SW = 16 + AW;

  logic [15:0] fit_mem [ENTRIES];
  logic [31:0] chr_mem [ENTRIES];
  logic        live_mem [ENTRIES];

  state_t st_r, st_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [31:0] rnd_r, rnd_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [5:0] div_r, div_nxt;
  logic any_r, any_nxt;
  logic [15:0] fit_rd_r;
  logic [31:0] chr_rd_r;
  logic q_live_r, q_ok_r;
  logic [AW-1:0] q_idx_r;
  logic [AW-1:0] pick_r, pick_nxt;
  logic valid_r, valid_nxt;
  logic exh_r, exh_nxt;
  logic [7:0] oidx_r, oidx_nxt;
  logic [31:0] ochr_r, ochr_nxt;

  logic do_start;
  logic idx_ok;
  logic load_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [SW:0] rem_sh, rem_sub;
  logic [SW-1:0] acc_add;

  assign do_start = start && !busy;
  assign busy = (st_r != ST_IDLE);
  assign idx_ok = ({24'd0, in_entry_index} < 32'(ENTRIES));
  assign load_we = do_start && (in_action == ACT_LOAD) && idx_ok;
  assign wr_addr = AW'({24'd0, in_entry_index});
  assign rd_addr = ptr_r[AW-1:0];
  assign acc_add = acc_r + SW'(fit_rd_r);
  assign rem_sh = {rem_r, rnd_r[31]};
  assign rem_sub = rem_sh - {1'b0, acc_r};

  // Table and live-mark memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (load_we) begin
      fit_mem[wr_addr] <= in_fitness;
      chr_mem[wr_addr] <= in_chromosome_word;
    end
    if (st_r == ST_CLR) begin
      live_mem[rd_addr] <= 1'b0;
    end else if (st_r == ST_OUT) begin
      live_mem[pick_r] <= 1'b0;
    end else if (load_we) begin
      live_mem[wr_addr] <= 1'b1;
    end
    fit_rd_r <= fit_mem[rd_addr];
    chr_rd_r <= chr_mem[rd_addr];
    q_idx_r <= rd_addr;
    q_live_r <= live_mem[rd_addr];
    q_ok_r <= (st_r == ST_SUM || st_r == ST_SCAN) && (ptr_r < CW'(ENTRIES));
  end

  always_comb begin
    st_nxt = st_r;
    ptr_nxt = ptr_r;
    acc_nxt = acc_r;
    rnd_nxt = rnd_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    any_nxt = any_r;
    pick_nxt = pick_r;
    valid_nxt = 1'b0;
    exh_nxt = exh_r;
    oidx_nxt = oidx_r;
    ochr_nxt = ochr_r;
    unique case (st_r)
      ST_CLR: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(ENTRIES - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (do_start) begin
          case (in_action)
            ACT_CLEAR: begin
              ptr_nxt = '0;
              st_nxt = ST_CLR;
            end
            ACT_SELECT: begin
              rnd_nxt = in_random_value;
              acc_nxt = '0;
              ptr_nxt = '0;
              any_nxt = 1'b0;
              st_nxt = ST_SUM;
            end
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        if (ptr_r < CW'(ENTRIES)) ptr_nxt = ptr_r + 1'b1;
        if (q_ok_r && q_live_r) begin
          acc_nxt = acc_add;
          any_nxt = 1'b1;
        end
        // end of sum pass: exhausted if no live entry was seen
        if (!q_ok_r && ptr_r == CW'(ENTRIES)) begin
          rem_nxt = '0;
          div_nxt = '0;
          st_nxt = any_r ? ST_MOD : ST_EXH;
        end
      end
      ST_MOD: begin
        // restoring remainder, one random bit per cycle; zero sum keeps 0
        if (acc_r == '0 || div_r == 6'd32) begin
          acc_nxt = '0;
          ptr_nxt = '0;
          st_nxt = ST_SCAN;
        end else begin
          rem_nxt = rem_sub[SW] ? rem_sh[SW-1:0] : rem_sub[SW-1:0];
          rnd_nxt = {rnd_r[30:0], 1'b0};
          div_nxt = div_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (ptr_r < CW'(ENTRIES)) ptr_nxt = ptr_r + 1'b1;
        if (q_ok_r && q_live_r) begin
          acc_nxt = acc_add;
          if (rem_r <= acc_add) begin
            pick_nxt = q_idx_r;
            ptr_nxt = {1'b0, q_idx_r};
            st_nxt = ST_RD;
          end
        end else if (!q_ok_r && ptr_r == CW'(ENTRIES)) begin
          st_nxt = ST_EXH;
        end
      end
      ST_RD: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        valid_nxt = 1'b1;
        exh_nxt = 1'b0;
        oidx_nxt = 8'(pick_r);
        ochr_nxt = chr_rd_r;
        st_nxt = ST_IDLE;
      end
      ST_EXH: begin
        valid_nxt = 1'b1;
        exh_nxt = 1'b1;
        oidx_nxt = '0;
        ochr_nxt = '0;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      ptr_r <= '0;
      valid_r <= 1'b0;
      exh_r <= 1'b0;
      oidx_r <= '0;
      ochr_r <= '0;
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      valid_r <= valid_nxt;
      exh_r <= exh_nxt;
      oidx_r <= oidx_nxt;
      ochr_r <= ochr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rnd_r <= rnd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    any_r <= any_nxt;
    pick_r <= pick_nxt;
  end

  assign out_valid = valid_r;
  assign out_exhausted = exh_r;
  assign out_chosen_index = oidx_r;
  assign out_chosen_chromosome = ochr_r;

  `RSW_ASSERT(a_st_onehot, clk, rst_n, $onehot(st_r), "state not one-hot")
  `RSW_ASSERT(a_out_idle, clk, rst_n, out_valid |-> st_r == ST_IDLE, "result while busy")
  `RSW_ASSERT(a_pick_live, clk, rst_n, st_r == ST_OUT |-> q_live_r, "picked entry not live")
  `RSW_ASSERT(a_div_range, clk, rst_n, st_r == ST_MOD |-> div_r <= 6'd32, "modulo overrun")
endmodule
